[hw/rtl/vtp_pkg.sv]
// ----------------------------------------------------------------------------
// vtp_pkg
// types and constants shared by the vertex transform blocks
// ----------------------------------------------------------------------------
package vtp_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int NUM_REGS      = 8;
	localparam int CFG_IDX_W     = 4;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] pos_w;
	} vtp_in_t;

	typedef struct packed {
		logic signed [31:0] clip_x;
		logic signed [31:0] clip_y;
		logic signed [31:0] clip_z;
		logic signed [31:0] clip_w;
		logic signed [31:0] ndc_x;
		logic signed [31:0] ndc_y;
		logic signed [31:0] ndc_z;
		logic               w_zero;
		logic               saturated;
	} vtp_out_t;

	typedef struct packed {
		logic signed [3:0][31:0] clip;
		logic                    sat;
		logic                    wz;
	} vtp_side_t;

endpackage

[hw/rtl/vtp_mac.sv]
// ----------------------------------------------------------------------------
// vtp_mac
// matrix times vector: products, row sums, shift and saturate in three stages
// ----------------------------------------------------------------------------
module vtp_mac import vtp_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  vtp_in_t                vtx,
	input  logic [NUM_REGS-1:0][63:0] coef,
	output logic                   out_valid,
	output logic signed [3:0][31:0] clip,
	output logic                   sat
);

	localparam int SW = 66;
	localparam int TW = SW - FRAC_BITS;

	logic signed [31:0] pos [4];
	logic signed [63:0] prod_s1 [16];
	logic signed [SW-1:0] sum_s2 [4];
	logic signed [31:0] clip_s3 [4];
	logic [3:0] sat_s3;
	logic v_s1, v_s2, v_s3;

	assign pos[0] = vtx.pos_x;
	assign pos[1] = vtx.pos_y;
	assign pos[2] = vtx.pos_z;
	assign pos[3] = vtx.pos_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	for (genvar r = 0; r < 4; r++) begin : g_row
		for (genvar k = 0; k < 4; k++) begin : g_col
			logic signed [31:0] c;
			if (k % 2 == 1) begin : g_hi
				assign c = $signed(coef[r*2 + k/2][63:32]);
			end else begin : g_lo
				assign c = $signed(coef[r*2 + k/2][31:0]);
			end
			always_ff @(posedge clk) begin
				prod_s1[r*4+k] <= c * pos[k];
			end
		end

		logic signed [TW-1:0] shr;
		logic ovf_hi, ovf_lo;
		assign shr    = TW'(sum_s2[r] >>> FRAC_BITS);
		assign ovf_hi = shr > $signed(TW'(64'sh7fff_ffff));
		assign ovf_lo = shr < -$signed(TW'(64'sh8000_0000));

		always_ff @(posedge clk) begin
			sum_s2[r] <= SW'(prod_s1[r*4]) + SW'(prod_s1[r*4+1])
				+ SW'(prod_s1[r*4+2]) + SW'(prod_s1[r*4+3]);
			if (ovf_hi) begin
				clip_s3[r] <= 32'sh7fff_ffff;
			end else if (ovf_lo) begin
				clip_s3[r] <= 32'sh8000_0000;
			end else begin
				clip_s3[r] <= shr[31:0];
			end
			sat_s3[r] <= ovf_hi | ovf_lo;
		end
		assign clip[r] = clip_s3[r];
	end

	assign out_valid = v_s3;
	assign sat       = |sat_s3;

endmodule

[hw/rtl/vtp_div.sv]
// ----------------------------------------------------------------------------
// vtp_div
// pipelined restoring divider, one quotient bit per stage, saturating
// ----------------------------------------------------------------------------
module vtp_div import vtp_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic signed [31:0] num,
	input  logic signed [31:0] den,
	output logic signed [31:0] quo,
	output logic               ovf
);

	localparam int QW = 32 + FRAC_BITS;

	logic [31:0]    rem_s [QW+1];
	logic [QW-1:0]  quo_s [QW+1];
	logic [QW-1:0]  num_s [QW+1];
	logic [31:0]    den_s [QW+1];
	logic           neg_s [QW+1];
	logic [31:0]    num_mag, den_mag;
	logic [QW-1:0]  q;
	logic signed [31:0] quo_q;
	logic           ovf_q;

	assign num_mag = num[31] ? 32'(-num) : num;
	assign den_mag = den[31] ? 32'(-den) : den;

	always_ff @(posedge clk) begin
		rem_s[0] <= '0;
		quo_s[0] <= '0;
		num_s[0] <= {num_mag, {FRAC_BITS{1'b0}}};
		den_s[0] <= den_mag;
		neg_s[0] <= num[31] ^ den[31];
	end

	for (genvar i = 0; i < QW; i++) begin : g_step
		logic [32:0] trial, diff;
		logic ge;
		assign trial = {rem_s[i], num_s[i][QW-1]};
		assign diff  = trial - {1'b0, den_s[i]};
		assign ge    = trial >= {1'b0, den_s[i]};
		always_ff @(posedge clk) begin
			rem_s[i+1] <= ge ? diff[31:0] : trial[31:0];
			quo_s[i+1] <= {quo_s[i][QW-2:0], ge};
			num_s[i+1] <= num_s[i] << 1;
			den_s[i+1] <= den_s[i];
			neg_s[i+1] <= neg_s[i];
		end
	end

	assign q = quo_s[QW];

	always_ff @(posedge clk) begin
		if (neg_s[QW]) begin
			if (q > QW'(64'h8000_0000)) begin
				quo_q <= 32'sh8000_0000;
				ovf_q <= 1'b1;
			end else begin
				quo_q <= 32'(-q[31:0]);
				ovf_q <= 1'b0;
			end
		end else begin
			if (q > QW'(64'h7fff_ffff)) begin
				quo_q <= 32'sh7fff_ffff;
				ovf_q <= 1'b1;
			end else begin
				quo_q <= q[31:0];
				ovf_q <= 1'b0;
			end
		end
	end

	assign quo = quo_q;
	assign ovf = ovf_q;

endmodule

[hw/rtl/vertex_transform_perspective_divide.sv]
// ----------------------------------------------------------------------------
// vertex_transform_perspective_divide
// 4x4 matrix vertex transform followed by the perspective divide
// ----------------------------------------------------------------------------
// usage:
//   input: a vertex is taken on each clock where start is high and busy is
//   low; busy is always low, so one vertex per cycle is sustained.
//   config: cfg_valid/cfg_ready write one 64-bit matrix register per
//   transaction at cfg_index; indexes past the eighth are ignored. write
//   only while no vertex is in flight.
//   output: done is high for one cycle with result valid; the result
//   follows its vertex through three stages of multiply, add and
//   saturate, then a divider that retires one quotient bit per stage
//   over 32 + FRAC_BITS stages plus input and output registers. data
//   is Q16.16 when FRAC_BITS is 16.
//   reset loads the identity matrix and drops all vertices in flight.
//   the receiver cannot stall; results are never held back.
// ----------------------------------------------------------------------------
module vertex_transform_perspective_divide import vtp_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  vtp_in_t              vtx,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data,
	output logic                 done,
	output vtp_out_t             result
);

	localparam int DIV_LAT = 32 + FRAC_BITS + 2;
	localparam int LAT     = 3 + DIV_LAT;
	localparam logic [63:0] ONE = 64'(1) << FRAC_BITS;

	logic [NUM_REGS-1:0][63:0] coef_q;
	logic mac_valid, mac_sat;
	logic signed [3:0][31:0] clip;
	logic signed [31:0] ndc [3];
	logic [2:0] ovf;
	vtp_side_t side_s [DIV_LAT];
	logic vld_s [DIV_LAT];
	vtp_side_t side_o;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q[0] <= ONE;
			coef_q[1] <= '0;
			coef_q[2] <= ONE << 32;
			coef_q[3] <= '0;
			coef_q[4] <= '0;
			coef_q[5] <= ONE;
			coef_q[6] <= '0;
			coef_q[7] <= ONE << 32;
		end else if (cfg_valid && cfg_index < CFG_IDX_W'(NUM_REGS)) begin
			coef_q[cfg_index[2:0]] <= cfg_data;
		end
	end

	vtp_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.vtx       (vtx),
		.coef      (coef_q),
		.out_valid (mac_valid),
		.clip      (clip),
		.sat       (mac_sat)
	);

	for (genvar i = 0; i < 3; i++) begin : g_div
		vtp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
			.clk (clk),
			.num (clip[i]),
			.den (clip[3]),
			.quo (ndc[i]),
			.ovf (ovf[i])
		);
	end

	// side data travels alongside the divider
	always_ff @(posedge clk) begin
		side_s[0].clip <= clip;
		side_s[0].sat  <= mac_sat;
		side_s[0].wz   <= clip[3] == 32'sd0;
		for (int i = 1; i < DIV_LAT; i++) begin
			side_s[i] <= side_s[i-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_LAT; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else begin
			vld_s[0] <= mac_valid;
			for (int i = 1; i < DIV_LAT; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	assign side_o = side_s[DIV_LAT-1];
	assign done   = vld_s[DIV_LAT-1];

	always_comb begin
		result.clip_x    = side_o.clip[0];
		result.clip_y    = side_o.clip[1];
		result.clip_z    = side_o.clip[2];
		result.clip_w    = side_o.clip[3];
		result.ndc_x     = side_o.wz ? 32'sd0 : ndc[0];
		result.ndc_y     = side_o.wz ? 32'sd0 : ndc[1];
		result.ndc_z     = side_o.wz ? 32'sd0 : ndc[2];
		result.w_zero    = side_o.wz;
		result.saturated = side_o.sat | (!side_o.wz & (|ovf));
	end

`ifndef SYNTHESIS
	a_latency : assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("result missing after fixed latency");
	a_wz_ndc : assert property (@(posedge clk) disable iff (!arst_n)
		done && result.w_zero |-> result.ndc_x == 32'sd0 && result.ndc_y == 32'sd0
			&& result.ndc_z == 32'sd0)
		else $error("ndc not forced to zero on zero clip w");
	a_wz_flag : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.w_zero == (result.clip_w == 32'sd0))
		else $error("w_zero disagrees with clip_w");
`endif

endmodule
